>>> rtl/core/aeir_pkg.sv
// Shared types, mode codes and GF(2^8) helpers for the AES inverse round core.
// Holds the inverse S-box table used by the row lanes.
// Depends on nothing; every other file imports it.
package aeir_pkg;

    typedef enum logic [1:0] {
        MODE_KEY_ADD = 2'd0,
        MODE_FULL    = 2'd1,
        MODE_FINAL   = 2'd2
    } mode_t;

    typedef logic [3:0][31:0] row_words_t;

    typedef struct packed {
        logic valid;
        logic do_mix;
    } stage_ctrl_t;

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,
        8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,
        8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,
        8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,
        8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,
        8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,
        8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,
        8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,
        8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,
        8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,
        8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,
        8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,
        8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,
        8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,
        8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,
        8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,
        8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // Multiply each of the four packed bytes by x modulo 0x11b.
    function automatic logic [31:0] xtime4(input logic [31:0] x);
        logic [31:0] r;
        for (int i = 0; i < 4; i++)
        begin
            r[8*i +: 8] = {x[8*i +: 7], 1'b0} ^ (x[8*i+7] ? 8'h1b : 8'h00);
        end
        return r;
    endfunction

endpackage

>>> rtl/core/aeir_row_lane.sv
// One row lane: inverse S-box on four bytes and inverse row rotation when do_sub is set, then key XOR.
// Depends on aeir_pkg for the S-box table.
module aeir_row_lane
    import aeir_pkg::*;
(
    input  logic        do_sub,
    input  logic [1:0]  row_idx,
    input  logic [31:0] row_in,
    input  logic [31:0] key_in,
    output logic [31:0] row_out
);

    logic [31:0] sub_word;
    logic [31:0] rot_word;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            sub_word[8*i +: 8] = INV_SBOX[row_in[8*i +: 8]];
        end
    end

    // Rotate left by 8 bits per row index.
    always_comb
    begin
        case (row_idx)
            2'd0:    rot_word = sub_word;
            2'd1:    rot_word = {sub_word[23:0], sub_word[31:24]};
            2'd2:    rot_word = {sub_word[15:0], sub_word[31:16]};
            2'd3:    rot_word = {sub_word[7:0], sub_word[31:8]};
            default: rot_word = sub_word;
        endcase
    end

    assign row_out = (do_sub ? rot_word : row_in) ^ key_in;

endmodule

>>> rtl/core/aeir_inv_mix.sv
// Merging stage: inverse MixColumns across the four row words, all columns at once.
// Depends on aeir_pkg for xtime4 and the row word type.
module aeir_inv_mix
    import aeir_pkg::*;
(
    input  logic       do_mix,
    input  row_words_t rows_in,
    output row_words_t rows_out
);

    logic [31:0] a0, a1, a2, a3;
    logic [31:0] d0, d1, d2, d3;
    logic [31:0] q0, q1, e;
    row_words_t  mixed;

    always_comb
    begin
        a0 = rows_in[0];
        a1 = rows_in[1];
        a2 = rows_in[2];
        a3 = rows_in[3];
        d0 = xtime4(a0);
        d1 = xtime4(a1);
        d2 = xtime4(a2);
        d3 = xtime4(a3);
        q0 = xtime4(d0 ^ d2);
        q1 = xtime4(d1 ^ d3);
        e  = xtime4(q0 ^ q1);
        mixed[0] = a1 ^ a2 ^ a3 ^ d0 ^ d1 ^ q0 ^ e;
        mixed[1] = a0 ^ a2 ^ a3 ^ d1 ^ d2 ^ q1 ^ e;
        mixed[2] = a0 ^ a1 ^ a3 ^ d2 ^ d3 ^ q0 ^ e;
        mixed[3] = a0 ^ a1 ^ a2 ^ d0 ^ d3 ^ q1 ^ e;
    end

    assign rows_out = do_mix ? mixed : rows_in;

endmodule

>>> rtl/core/aes_inverse_round_core.sv
// Top level of the AES inverse round core: four row lanes, a stage register,
// the inverse MixColumns merge and the result register.
// Depends on aeir_pkg, aeir_row_lane and aeir_inv_mix.
//
// Usage: pulse start with mode, state and round key; a transaction is taken in
// every cycle, since busy never rises. After the stage register and the result
// register, done is high for exactly one cycle with result_lo/result_hi. One
// round per clock is sustained; the first register sits after the four inverse
// S-box row lanes and key XOR, the second after the inverse MixColumns merge.
// The receiver cannot stall, so it must capture result on every done cycle.
// Mode 0 and the unused mode 3 only XOR the key; mode 1 runs a full inverse
// round; mode 2 is the final round without MixColumns. State is row-packed:
// byte 4r+c is row r, column c, and row r is a little-endian 32-bit word.
module aes_inverse_round_core
    import aeir_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [63:0] state_lo,
    input  logic [63:0] state_hi,
    input  logic [63:0] round_key_lo,
    input  logic [63:0] round_key_hi,
    output logic        done,
    output logic [63:0] result_lo,
    output logic [63:0] result_hi
);

    row_words_t  state_rows;
    row_words_t  key_rows;
    row_words_t  lane_rows;
    row_words_t  mix_rows;
    logic        accept;
    logic        do_sub;
    stage_ctrl_t ctrl_next;
    stage_ctrl_t ctrl_reg;
    row_words_t  rows_reg;
    logic        done_reg;
    logic [63:0] result_lo_reg;
    logic [63:0] result_hi_reg;

    // Fully pipelined, nothing ever holds the input side off.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign state_rows = {state_hi, state_lo};
    assign key_rows   = {round_key_hi, round_key_lo};

    // Substitution and row shift only for the full and final rounds.
    assign do_sub = (mode == MODE_FULL) || (mode == MODE_FINAL);

    for (genvar r = 0; r < 4; r++)
    begin : g_lane
        aeir_row_lane u_lane (
            .do_sub  (do_sub),
            .row_idx (2'(r)),
            .row_in  (state_rows[r]),
            .key_in  (key_rows[r]),
            .row_out (lane_rows[r])
        );
    end

    always_comb
    begin
        ctrl_next.valid  = accept;
        ctrl_next.do_mix = (mode == MODE_FULL);
    end

    // Advance control through the two stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
            done_reg <= ctrl_reg.valid;
        end
    end

    // Payload: capture only on a live transaction, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rows_reg <= lane_rows;
        end
        if (ctrl_reg.valid)
        begin
            result_lo_reg <= {mix_rows[1], mix_rows[0]};
            result_hi_reg <= {mix_rows[3], mix_rows[2]};
        end
    end

    aeir_inv_mix u_mix (
        .do_mix   (ctrl_reg.do_mix),
        .rows_in  (rows_reg),
        .rows_out (mix_rows)
    );

    assign done      = done_reg;
    assign result_lo = result_lo_reg;
    assign result_hi = result_hi_reg;

    // Every accepted transaction reaches the result strobe through the stage register and the result register.
    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 done)
        else $error("accepted transaction did not produce done");

    // No result strobe without a matching accepted transaction.
    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> ##1 !done)
        else $error("done without an accepted transaction");

    // A round without mix passes the stage register straight to the result.
    a_nomix_passthru: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_reg.valid && !ctrl_reg.do_mix)
        |=> (result_lo == $past({rows_reg[1], rows_reg[0]}))
            && (result_hi == $past({rows_reg[3], rows_reg[2]})))
        else $error("result differs from stage data on a round without mix");

endmodule
